[hw/rtl/slcd_pkg.sv]
`timescale 1ns / 1ps
package slcd_pkg;

	localparam int unsigned VALUE_W   = 20;
	localparam int unsigned DIGITS    = 6;
	localparam int unsigned DIGIT_W   = 4;
	localparam int unsigned INIT_LEN  = 9;
	localparam int unsigned ROW1_LEN  = 6;
	localparam int unsigned ROW2_LEN  = 10;

	localparam logic [VALUE_W-1:0] MAX_VALUE = 20'd999999;

	localparam logic [7:0] CMD_ROW2   = 8'h80 | 8'h40;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam logic [7:0] INIT_CMD [INIT_LEN] = '{
		8'h30, 8'h30, 8'h30, 8'h38, 8'h08, 8'h01, 8'h06, 8'h0c, 8'h02
	};
	localparam logic INIT_LONG [INIT_LEN] = '{
		1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1
	};
	localparam logic [7:0] ROW1_TEXT [ROW1_LEN] = '{
		"S", "c", "o", "r", "e", ":"
	};
	localparam logic [7:0] ROW2_TEXT [ROW2_LEN] = '{
		"H", "i", "g", "h", "S", "c", "o", "r", "e", ":"
	};
	localparam logic [VALUE_W-1:0] PLACE [DIGITS] = '{
		20'd100000, 20'd10000, 20'd1000, 20'd100, 20'd10, 20'd1
	};

	typedef struct packed {
		logic [VALUE_W-1:0] score;
		logic [VALUE_W-1:0] high_score;
	} req_t;

	typedef enum logic [2:0] {
		PH_INIT,
		PH_TXT1,
		PH_NUM1,
		PH_MOVE,
		PH_TXT2,
		PH_NUM2
	} phase_t;

	function automatic logic [VALUE_W-1:0] saturate(input logic [VALUE_W-1:0] v);
		return (v > MAX_VALUE) ? MAX_VALUE : v;
	endfunction

	// index of the first nonzero digit, digit 0 being the most significant;
	// the ones digit is always shown
	function automatic logic [2:0] first_shown(input logic [DIGITS*DIGIT_W-1:0] digs);
		logic [2:0] idx;
		idx = 3'(DIGITS - 1);
		for (int k = DIGITS - 1; k >= 0; k--) begin
			if (digs[k*DIGIT_W +: DIGIT_W] != '0) begin
				idx = 3'(k);
			end
		end
		return idx;
	endfunction

endpackage

[hw/rtl/slcd_digits.sv]
`timescale 1ns / 1ps
// Decimal digit extraction, one digit per cycle: score digits first,
// then high score digits.
module slcd_digits (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  slcd_pkg::req_t         req,
	output logic [2*slcd_pkg::DIGITS*slcd_pkg::DIGIT_W-1:0] digits
);
	import slcd_pkg::*;

	localparam int unsigned STEPS = 2 * DIGITS;

	logic               active_q;
	logic [3:0]         step_q;
	logic [2:0]         place_idx;
	logic [VALUE_W-1:0] rem_q;
	logic [VALUE_W-1:0] hi_q;
	logic [VALUE_W-1:0] place;
	logic [VALUE_W-1:0] mult [10];
	logic [DIGIT_W-1:0] dig;
	logic [VALUE_W-1:0] sub;
	logic [DIGIT_W-1:0] digits_q [STEPS];

	assign place_idx = (step_q < 4'(DIGITS)) ? step_q[2:0] : 3'(step_q - 4'(DIGITS));
	assign place     = PLACE[place_idx];

	// largest multiple of the place value that fits
	always_comb begin
		dig = '0;
		sub = '0;
		for (int j = 0; j < 10; j++) begin
			mult[j] = VALUE_W'(place * VALUE_W'(j));
		end
		for (int j = 1; j < 10; j++) begin
			if (rem_q >= mult[j]) begin
				dig = DIGIT_W'(j);
				sub = mult[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			step_q   <= '0;
		end else if (active_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == 4'(STEPS - 1)) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= saturate(req.score);
			hi_q  <= saturate(req.high_score);
		end else if (active_q) begin
			rem_q <= (step_q == 4'(DIGITS - 1)) ? hi_q : rem_q - sub;
			digits_q[step_q] <= dig;
		end
	end

	always_comb begin
		for (int i = 0; i < STEPS; i++) begin
			digits[i*DIGIT_W +: DIGIT_W] = digits_q[i];
		end
	end

endmodule

[hw/rtl/slcd_seq.sv]
`timescale 1ns / 1ps
// Write sequencer with the output register.
module slcd_seq (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2*slcd_pkg::DIGITS*slcd_pkg::DIGIT_W-1:0] digits,
	output logic       busy,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_rs,
	output logic [7:0] out_byte,
	output logic       out_long,
	output logic       out_last
);
	import slcd_pkg::*;

	localparam int unsigned NUM_W = DIGITS * DIGIT_W;

	phase_t     phase_q, phase_d;
	logic [3:0] cnt_q, cnt_d;
	logic       busy_q, busy_d;
	logic       fire;
	logic       wr_rs, wr_long, wr_last;
	logic [7:0] wr_byte;
	logic [NUM_W-1:0] digs1, digs2;

	logic       valid_q;
	logic       rs_q, long_q, last_q;
	logic [7:0] byte_q;

	assign digs1 = digits[NUM_W-1:0];
	assign digs2 = digits[2*NUM_W-1:NUM_W];
	assign fire  = busy_q && (!valid_q || out_ready);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q + 4'd1;
		busy_d  = busy_q;
		wr_rs   = RS_DATA;
		wr_byte = '0;
		wr_long = 1'b0;
		wr_last = 1'b0;
		unique case (phase_q)
			PH_INIT: begin
				wr_rs   = RS_CMD;
				wr_byte = INIT_CMD[cnt_q];
				wr_long = INIT_LONG[cnt_q];
				if (cnt_q == 4'(INIT_LEN - 1)) begin
					phase_d = PH_TXT1;
					cnt_d   = '0;
				end
			end
			PH_TXT1: begin
				wr_byte = ROW1_TEXT[cnt_q[2:0]];
				if (cnt_q == 4'(ROW1_LEN - 1)) begin
					phase_d = PH_NUM1;
					cnt_d   = {1'b0, first_shown(digs1)};
				end
			end
			PH_NUM1: begin
				wr_byte = ASCII_ZERO + 8'(digs1[cnt_q[2:0]*DIGIT_W +: DIGIT_W]);
				if (cnt_q == 4'(DIGITS - 1)) begin
					phase_d = PH_MOVE;
				end
			end
			PH_MOVE: begin
				wr_rs   = RS_CMD;
				wr_byte = CMD_ROW2;
				phase_d = PH_TXT2;
				cnt_d   = '0;
			end
			PH_TXT2: begin
				wr_byte = ROW2_TEXT[cnt_q];
				if (cnt_q == 4'(ROW2_LEN - 1)) begin
					phase_d = PH_NUM2;
					cnt_d   = {1'b0, first_shown(digs2)};
				end
			end
			PH_NUM2: begin
				wr_byte = ASCII_ZERO + 8'(digs2[cnt_q[2:0]*DIGIT_W +: DIGIT_W]);
				if (cnt_q == 4'(DIGITS - 1)) begin
					wr_last = 1'b1;
					busy_d  = 1'b0;
				end
			end
			default: begin
				busy_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_INIT;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= PH_INIT;
				cnt_q   <= '0;
			end else if (fire) begin
				busy_q  <= busy_d;
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
			end
			if (fire) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rs_q   <= wr_rs;
			byte_q <= wr_byte;
			long_q <= wr_long;
			last_q <= wr_last;
		end
	end

	assign busy      = busy_q;
	assign out_valid = valid_q;
	assign out_rs    = rs_q;
	assign out_byte  = byte_q;
	assign out_long  = long_q;
	assign out_last  = last_q;

endmodule

[hw/rtl/score_lcd_write_sequencer.sv]
`timescale 1ns / 1ps
// Character LCD write sequencer for a score display.
// Input stream (s_axis): one request carries a score and a high score.
// Output stream (m_axis): one LCD bus write per transfer: the nine-command
// 8-bit init, "Score:" and the score, a move to row two, "HighScore:" and
// the high score. Leading zeros are blanked; values over 999999 saturate.
// tuser is register select (0 = command, 1 = character), tdata[8] the
// long-wait class, tlast marks the final write of the run.
// A request sits in an input register until the sequencer is free, so the
// next request is taken while the current run is still going out.
// A request starts from the input register once the sequencer is idle, and
// its first write goes out through the output register. A run is 28 to 38
// writes, one per cycle while tready stays high. The write counter steps
// through each run, and the one-digit-per-cycle decimal converter is hidden
// behind the init commands and the row-one text.
// When the receiver stalls, the write in the output register holds and the
// sequencer waits. Reset empties the input and output registers and
// returns the sequencer to idle.
module score_lcd_write_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // score[19:0], high_score[39:20]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // data_byte[7:0], long_wait[8], zero[15:9]
	output logic        m_axis_tuser,   // register_select[0]
	output logic        m_axis_tlast
);
	import slcd_pkg::*;

	logic  req_valid_q;
	req_t  req_q;
	logic  busy;
	logic  start;
	logic  out_rs, out_long;
	logic [7:0] out_byte;
	logic [2*DIGITS*DIGIT_W-1:0] digits;

	assign s_axis_tready = !req_valid_q;
	assign start         = req_valid_q && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			req_valid_q <= 1'b1;
		end else if (start) begin
			req_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_q.score      <= s_axis_tdata[19:0];
			req_q.high_score <= s_axis_tdata[39:20];
		end
	end

	slcd_digits u_digits (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req_q),
		.digits (digits)
	);

	slcd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.digits    (digits),
		.busy      (busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rs    (out_rs),
		.out_byte  (out_byte),
		.out_long  (out_long),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {7'b0, out_long, out_byte};
	assign m_axis_tuser = out_rs;

endmodule
